// ===== rtl/packet_header_length_deframer_macros.svh =====
// Assertion macros used by the deframer's top-level RTL file.
`ifndef PACKET_HEADER_LENGTH_DEFRAMER_MACROS_SVH
`define PACKET_HEADER_LENGTH_DEFRAMER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define PHLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define PHLD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phld_pkg.sv =====
// Package with the types, codes and reset values of the deframer.
package phld_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int HDR_CNT_W = 2;

  localparam logic [BYTE_W-1:0] KIND_TOPIC    = 8'd0;
  localparam logic [BYTE_W-1:0] KIND_IDENTITY = 8'd255;
  localparam logic [HDR_CNT_W-1:0] HDR_TYPE   = 2'd0;
  localparam logic [HDR_CNT_W-1:0] HDR_TAG    = 2'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO = 2'd2;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TOPIC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd1;

  localparam logic [BYTE_W-1:0] TOPIC_COUNT_RESET = 8'd16;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET  = 16'd256;

  typedef enum logic {
    ST_HEADER,
    ST_PAYLOAD
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] topic_count;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] topic;
    logic [BYTE_W-1:0] data;
    logic              data_valid;
    logic [LEN_W-1:0]  offset;
    logic              last;
  } result_t;

endpackage

// ===== rtl/phld_byte_if.sv =====
// Channel that carries one received byte per request.
interface phld_byte_if
  import phld_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/phld_result_if.sv =====
// Channel that carries one deframer result per request.
interface phld_result_if
  import phld_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] topic;
  logic [BYTE_W-1:0] data;
  logic              data_valid;
  logic [LEN_W-1:0]  offset;
  logic              last;

  modport source (output valid, output kind, output topic, output data,
                  output data_valid, output offset, output last, input ready);
  modport sink (input valid, input kind, input topic, input data,
                input data_valid, input offset, input last, output ready);
endinterface

// ===== rtl/phld_cfg_regs.sv =====
// Configuration registers for the topic count and the length limit.
module phld_cfg_regs
  import phld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.topic_count <= TOPIC_COUNT_RESET;
      cfg.max_length  <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOPIC_COUNT: cfg.topic_count <= cfg_data[BYTE_W-1:0];
        REG_MAX_LENGTH:  cfg.max_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/phld_parser.sv =====
// Header collector and payload counter that decides the result of each byte.
module phld_parser
  import phld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cfg_t              cfg,
  output logic              emit,
  output result_t           res
);

  state_t                state;
  state_t                state_next;
  logic [HDR_CNT_W-1:0]  header_count;
  logic [BYTE_W-1:0]     packet_kind;
  logic [BYTE_W-1:0]     hdr_tag;
  logic [BYTE_W-1:0]     length_low;
  logic [LEN_W-1:0]      bytes_left;
  logic [LEN_W-1:0]      payload_offset;
  logic [LEN_W-1:0]      payload_offset_next;

  logic [LEN_W-1:0] len;
  logic             header_ok;
  logic             header_done;
  logic [LEN_W-1:0] left_dec;
  logic             final_byte;
  logic             is_identity;

  assign len         = {rx_byte, length_low};
  assign header_done = (header_count == HDR_LEN_HI);
  assign is_identity = (packet_kind == KIND_IDENTITY);
  assign left_dec    = bytes_left - LEN_W'(1);
  assign final_byte  = (left_dec == '0);

  always_comb begin
    if (packet_kind == KIND_TOPIC) begin
      header_ok = (hdr_tag < cfg.topic_count) && (len < cfg.max_length);
    end else begin
      header_ok = is_identity;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_HEADER: begin
        if (header_done && header_ok && (len != '0)) begin
          state_next = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (final_byte) begin
          state_next = ST_HEADER;
        end
      end
      default: state_next = ST_HEADER;
    endcase
  end

  always_comb begin
    emit                = 1'b0;
    res                 = '0;
    res.kind            = is_identity;
    res.topic           = hdr_tag;
    payload_offset_next = payload_offset;
    case (state)
      ST_HEADER: begin
        payload_offset_next = '0;
        if (header_done && header_ok && (len == '0)) begin
          emit     = 1'b1;
          res.last = 1'b1;
        end
      end
      ST_PAYLOAD: begin
        payload_offset_next = final_byte ? '0 : payload_offset + LEN_W'(1);
        res.last            = final_byte;
        if (!is_identity) begin
          emit           = 1'b1;
          res.data       = rx_byte;
          res.data_valid = 1'b1;
          res.offset     = payload_offset;
        end else begin
          emit = final_byte;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_HEADER;
      header_count   <= HDR_TYPE;
      packet_kind    <= KIND_TOPIC;
      hdr_tag        <= '0;
      length_low     <= '0;
      bytes_left     <= '0;
      payload_offset <= '0;
    end else if (accept) begin
      state          <= state_next;
      payload_offset <= payload_offset_next;
      if (state == ST_HEADER) begin
        header_count <= header_count + HDR_CNT_W'(1);
        case (header_count)
          HDR_TYPE:   packet_kind <= rx_byte;
          HDR_TAG:    hdr_tag     <= rx_byte;
          HDR_LEN_LO: length_low  <= rx_byte;
          HDR_LEN_HI: bytes_left  <= len;
          default: ;
        endcase
      end else begin
        bytes_left <= left_dec;
      end
    end
  end

endmodule

// ===== rtl/phld_out_reg.sv =====
// Result register that holds one result until the receiver takes it.
module phld_out_reg
  import phld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    space,
  phld_result_if.source tx
);

  result_t held;
  logic    valid;

  assign space = !valid || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      held <= res;
    end
  end

  assign tx.valid      = valid;
  assign tx.kind       = held.kind;
  assign tx.topic      = held.topic;
  assign tx.data       = held.data;
  assign tx.data_valid = held.data_valid;
  assign tx.offset     = held.offset;
  assign tx.last       = held.last;

endmodule

// ===== rtl/packet_header_length_deframer.sv =====
// Top level of the packet header and length deframer.
//
// The rx channel takes one received byte per request. Every packet opens with
// a four-byte header: type, topic tag, then the payload length low byte first.
// Topic messages give one result per payload byte with its offset, and the
// final byte carries last. Identity requests give a single result with last
// set on their final byte. A valid header with zero length gives its result on
// the last header byte. Headers of other types or failing the limits are
// dropped without a result.
// The result channel shows each result in the cycle after its byte is accepted,
// from a single result register. One byte is accepted in every cycle in which
// rx.valid and rx.ready are both high. When the receiver stalls with a result
// waiting, rx.ready drops until that result is taken; no byte is lost.
// The cfg port writes topic_count at index 0 and the length limit at index 1.
// Reset is synchronous and restores the register defaults, empties the result
// register and starts looking for a header.
`include "packet_header_length_deframer_macros.svh"

module packet_header_length_deframer
  import phld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  phld_byte_if.sink             rx,
  phld_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    emit;
  logic    space;
  logic    accept;

  assign rx.ready = space;
  assign accept   = rx.valid && space;

  phld_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  phld_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .emit    (emit),
    .res     (res)
  );

  phld_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (accept && emit),
    .res   (res),
    .space (space),
    .tx    (result)
  );

  `PHLD_ASSERT(a_stall_blocks_rx, (result.valid && !result.ready) |-> !rx.ready,
               "rx taken while result stalled")
  `PHLD_ASSERT(a_data_only_topic, (result.valid && result.data_valid) |-> !result.kind,
               "identity result with data")
  `PHLD_ASSERT(a_identity_last,
               (result.valid && result.kind) |-> (result.last && !result.data_valid),
               "identity result not final")
  `PHLD_ASSERT_ALWAYS(a_reset_empty, rst |=> !result.valid, "result valid after reset")

endmodule

// ===== tb/sv/packet_header_length_deframer_test.sv =====
// Self-checking testbench that streams framed packets into the deframer and checks results.
`timescale 1ns / 1ps

module packet_header_length_deframer_test;
  import phld_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [BYTE_W-1:0] KIND_UNKNOWN = 8'd7;
  localparam int MAX_IDLE = 12;
  localparam int SETTLE_CYCLES = 4;

  class deframe_tracker;
    logic [BYTE_W-1:0] topic_count;
    logic [LEN_W-1:0] max_length;
    state_t stage;
    logic [HDR_CNT_W-1:0] hdr_pos;
    logic [BYTE_W-1:0] pkt_kind;
    logic [BYTE_W-1:0] tag;
    logic [BYTE_W-1:0] len_lo;
    logic [LEN_W:0] left;
    logic [LEN_W-1:0] off;
    result_t expected_q[$];
    int errors;

    function new();
      topic_count = TOPIC_COUNT_RESET;
      max_length = MAX_LENGTH_RESET;
      stage = ST_HEADER;
      hdr_pos = HDR_TYPE;
      pkt_kind = '0;
      tag = '0;
      len_lo = '0;
      left = '0;
      off = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TOPIC_COUNT: topic_count = val[BYTE_W-1:0];
        REG_MAX_LENGTH: max_length = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void queue_result(logic [BYTE_W-1:0] d, logic dv, logic [LEN_W-1:0] o, logic l);
      result_t r;
      r.kind = (pkt_kind == KIND_IDENTITY);
      r.topic = tag;
      r.data = d;
      r.data_valid = dv;
      r.offset = o;
      r.last = l;
      expected_q.push_back(r);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      logic ok;
      if (stage == ST_HEADER) begin
        case (hdr_pos)
          HDR_TYPE: pkt_kind = b;
          HDR_TAG: tag = b;
          HDR_LEN_LO: len_lo = b;
          default: begin
            len = {b, len_lo};
            if (pkt_kind == KIND_TOPIC) begin
              ok = (tag < topic_count) && (len < max_length);
            end else begin
              ok = (pkt_kind == KIND_IDENTITY);
            end
            if (ok && len == 0) begin
              queue_result('0, 1'b0, '0, 1'b1);
            end else if (ok) begin
              stage = ST_PAYLOAD;
              left = {1'b0, len};
              off = '0;
            end
          end
        endcase
        hdr_pos = hdr_pos + 1'b1;
      end else begin
        left = left - 1'b1;
        if (pkt_kind == KIND_TOPIC) begin
          queue_result(b, 1'b1, off, left == 0);
        end else if (left == 0) begin
          queue_result('0, 1'b0, '0, 1'b1);
        end
        off = off + 1'b1;
        if (left == 0) begin
          stage = ST_HEADER;
          off = '0;
        end
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting: topic %0h data %0h", got.topic, got.data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("kind", want.kind, got.kind);
      compare("topic", want.topic, got.topic);
      compare("data", want.data, got.data);
      compare("data_valid", want.data_valid, got.data_valid);
      compare("offset", want.offset, got.offset);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit no_stall;

  phld_byte_if rx_if();
  phld_result_if res_if();

  deframe_tracker tracker = new();

  packet_header_length_deframer u_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .result(res_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #600000;
    $display("packet_header_length_deframer: mismatch");
    $finish;
  end

  function automatic int idle_draw();
    return no_stall ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    tracker.take_byte(b);
  endtask

  task automatic send_header(input logic [BYTE_W-1:0] kind_b, input logic [BYTE_W-1:0] tag_b,
                             input logic [LEN_W-1:0] len);
    send_byte(kind_b);
    send_byte(tag_b);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic send_payload(input int unsigned len);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [BYTE_W-1:0] tc, input logic [LEN_W-1:0] bs);
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_IDX_W-1:0] spare;
    word = {8'($urandom_range(0, 255)), tc};
    spare = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_we <= 1'b1;
    cfg_index <= REG_TOPIC_COUNT;
    cfg_data <= word;
    @(posedge clk);
    tracker.write_reg(REG_TOPIC_COUNT, word);
    word = 16'($urandom);
    cfg_index <= spare;
    cfg_data <= word;
    @(posedge clk);
    tracker.write_reg(spare, word);
    cfg_index <= REG_MAX_LENGTH;
    cfg_data <= bs;
    @(posedge clk);
    tracker.write_reg(REG_MAX_LENGTH, bs);
    cfg_we <= 1'b0;
  endtask

  task automatic send_packet(inout int unsigned counted);
    int unsigned pick;
    int unsigned len;
    int unsigned tag_v;
    int unsigned tc;
    int unsigned bs;
    tc = tracker.topic_count;
    bs = tracker.max_length;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) settle();
    if (pick < 65) begin
      tag_v = (tc == 0) ? $urandom_range(0, 255) : $urandom_range(0, tc - 1);
      len = $urandom_range(0, ($urandom_range(0, 19) == 0) ? 64 : 10);
      if (bs == 0) begin
        len = 0;
      end else if (len > bs - 1) begin
        len = bs - 1;
      end
      send_header(KIND_TOPIC, 8'(tag_v), 16'(len));
      if (tag_v < tc && len < bs) begin
        send_payload(len);
        counted += 4 + len;
      end
    end else if (pick < 80) begin
      len = ($urandom_range(0, 24) == 0) ? 300 : $urandom_range(0, 12);
      send_header(KIND_IDENTITY, 8'($urandom_range(0, 255)), 16'(len));
      send_payload(len);
      counted += 4 + len;
    end else if (pick < 88) begin
      send_header(8'($urandom_range(1, 254)), 8'($urandom_range(0, 255)),
                  16'($urandom_range(0, 65535)));
    end else if (pick < 94) begin
      send_header(KIND_TOPIC, 8'($urandom_range(tc, 255)), 16'($urandom_range(0, 8)));
    end else begin
      tag_v = (tc == 0) ? 0 : $urandom_range(0, tc - 1);
      send_header(KIND_TOPIC, 8'(tag_v), 16'($urandom_range(bs, 65535)));
    end
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] tc, input logic [LEN_W-1:0] bs,
                           input int unsigned n_bytes);
    int unsigned counted;
    counted = 0;
    settle();
    write_regs(tc, bs);
    while (counted < n_bytes) send_packet(counted);
  endtask

  initial begin
    result_t got;
    int gap;
    res_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got = '{kind: res_if.kind, topic: res_if.topic, data: res_if.data,
              data_valid: res_if.data_valid, offset: res_if.offset, last: res_if.last};
      tracker.match_result(got);
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TOPIC_COUNT;
    cfg_data = '0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    no_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Zero-length topic message at the highest legal tag, then an identity
    // request whose tag is far above the topic count.
    send_header(KIND_TOPIC, 8'd15, 16'd0);
    send_header(KIND_IDENTITY, 8'd200, 16'd0);
    send_header(KIND_TOPIC, 8'd0, 16'd1);
    send_byte(8'hFF);
    send_header(KIND_UNKNOWN, 8'd1, 16'd0);
    send_header(KIND_TOPIC, 8'd16, 16'd1);
    send_header(KIND_TOPIC, 8'd0, 16'd256);

    run_phase(8'd255, 16'hFFFF, 80);
    settle();
    no_stall = 1'b1;
    send_header(KIND_IDENTITY, 8'($urandom_range(0, 255)), 16'd40);
    send_payload(40);
    send_header(KIND_TOPIC, 8'd254, 16'd300);
    send_payload(300);
    no_stall = 1'b0;

    no_stall = 1'b1;
    run_phase(8'd1, 16'd1, 40);
    no_stall = 1'b0;
    run_phase(8'd0, 16'd0, 20);
    repeat (2) run_phase(8'($urandom_range(1, 255)), 16'($urandom_range(1, 600)), 60);
    run_phase(TOPIC_COUNT_RESET, MAX_LENGTH_RESET, 30);
    settle();

    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("packet_header_length_deframer: match");
    end else begin
      $display("packet_header_length_deframer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/phld_pkg.sv
rtl/phld_byte_if.sv
rtl/phld_result_if.sv
rtl/phld_cfg_regs.sv
rtl/phld_parser.sv
rtl/phld_out_reg.sv
rtl/packet_header_length_deframer.sv
tb/sv/packet_header_length_deframer_test.sv
